// ----- design/gbnp3d_pkg.sv -----
// Shared types and constants for the 3D grid-bucket nearest-point unit.
// No dependencies.
package gbnp3d_pkg;

    localparam int MAX_GRID_DEF   = 16;
    localparam int MAX_POINTS_DEF = 4096;
    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_W          = 5;
    localparam int OP_W           = 2;
    localparam int IN_COORD_W     = 16;
    localparam int TAG_W          = 16;
    localparam int STAT_W         = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_CLEARED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_OWN      = 3'd3,
        ST_NBR      = 3'd4,
        ST_NONE     = 3'd5
    } t_status;

    typedef struct packed {
        logic    load;
        logic    clr_step;
        logic    idx_mul;
        logic    idx_clamp;
        logic    adr_kj;
        logic    adr_fin;
        logic    rd_head;
        logic    ins;
        logic    pt_first;
        logic    rd_pt;
        logic    dist_sq;
        logic    dist_acc;
        logic    ring_d1;
        logic    ring_bounds;
        logic    ring_step;
        logic    res_we;
        t_status res_code;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic clr_last;
        logic head_nz;
        logic nxt_nz;
        logic centre;
        logic box_end;
        logic ring_more;
    } t_stat;

endpackage

// ----- design/gbnp3d_ctrl.sv -----
// Sequencer for the grid-bucket unit: clear sweep, insert, chain walk, ring scan.
// Depends on gbnp3d_pkg.
module gbnp3d_ctrl import gbnp3d_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_opcode,
    input  t_stat           i_stat,
    output t_cmd            o_cmd,
    output logic            o_busy,
    output logic            o_valid
);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_CLR   = 16'h0002,
        S_IDX   = 16'h0004,
        S_CLAMP = 16'h0008,
        S_KJ    = 16'h0010,
        S_AD    = 16'h0020,
        S_RDH   = 16'h0040,
        S_HEAD  = 16'h0080,
        S_BND   = 16'h0100,
        S_CHK   = 16'h0200,
        S_STEP  = 16'h0400,
        S_RDP   = 16'h0800,
        S_SQ    = 16'h1000,
        S_ACC   = 16'h2000,
        S_OWN   = 16'h4000,
        S_DONE  = 16'h8000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_ring, n_ring;
    logic   r_clr_op, n_clr_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_op     <= OP_NOP;
            r_ring   <= 1'b0;
            r_clr_op <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_ring   <= n_ring;
            r_clr_op <= n_clr_op;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_ring   = r_ring;
        n_clr_op = r_clr_op;
        o_cmd    = '0;
        o_cmd.res_code = ST_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_op       = t_op'(i_opcode);
                    n_ring     = 1'b0;
                    case (t_op'(i_opcode))
                        OP_CLEAR: begin
                            n_clr_op = 1'b1;
                            n_state  = S_CLR;
                        end
                        OP_INSERT: begin
                            if (i_stat.full) begin
                                o_cmd.res_we   = 1'b1;
                                o_cmd.res_code = ST_FULL;
                                n_state        = S_DONE;
                            end else begin
                                n_state = S_IDX;
                            end
                        end
                        OP_QUERY: n_state = S_IDX;
                        default: begin
                            o_cmd.res_we   = 1'b1;
                            o_cmd.res_code = ST_NONE;
                            n_state        = S_DONE;
                        end
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_clr_op = 1'b0;
                    if (r_clr_op) begin
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_code = ST_CLEARED;
                        n_state        = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDX: begin
                o_cmd.idx_mul = 1'b1;
                n_state       = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.idx_clamp = 1'b1;
                n_state         = S_KJ;
            end
            S_KJ: begin
                o_cmd.adr_kj = 1'b1;
                n_state      = S_AD;
            end
            S_AD: begin
                o_cmd.adr_fin = 1'b1;
                n_state       = S_RDH;
            end
            S_RDH: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_HEAD;
            end
            S_HEAD: begin
                if (r_op == OP_INSERT) begin
                    o_cmd.ins      = 1'b1;
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_code = ST_INSERTED;
                    n_state        = S_DONE;
                end else if (i_stat.head_nz) begin
                    o_cmd.pt_first = 1'b1;
                    n_state        = S_RDP;
                end else if (r_ring) begin
                    n_state = S_STEP;
                end else begin
                    o_cmd.ring_d1 = 1'b1;
                    n_state       = S_BND;
                end
            end
            S_BND: begin
                o_cmd.ring_bounds = 1'b1;
                n_ring            = 1'b1;
                n_state           = S_CHK;
            end
            S_CHK: begin
                n_state = i_stat.centre ? S_STEP : S_KJ;
            end
            S_STEP: begin
                o_cmd.ring_step = 1'b1;
                if (!i_stat.box_end) begin
                    n_state = S_CHK;
                end else if (i_stat.ring_more) begin
                    n_state = S_BND;
                end else begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_code = ST_NONE;
                    n_state        = S_DONE;
                end
            end
            S_RDP: begin
                o_cmd.rd_pt = 1'b1;
                n_state     = S_SQ;
            end
            S_SQ: begin
                if (r_ring) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_code = ST_NBR;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.dist_sq = 1'b1;
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.dist_acc = 1'b1;
                n_state        = i_stat.nxt_nz ? S_RDP : S_OWN;
            end
            S_OWN: begin
                o_cmd.res_we   = 1'b1;
                o_cmd.res_code = ST_OWN;
                n_state        = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// ----- design/gbnp3d_dp.sv -----
// Datapath for the grid-bucket unit: cell heads, point store, index and distance arithmetic.
// Depends on gbnp3d_pkg.
module gbnp3d_dp import gbnp3d_pkg::*; #(
    parameter int MAX_GRID   = MAX_GRID_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic [$clog2(MAX_GRID+1)-1:0] i_g,
    input  logic [IN_COORD_W-1:0]         i_coord_x,
    input  logic [IN_COORD_W-1:0]         i_coord_y,
    input  logic [IN_COORD_W-1:0]         i_coord_z,
    input  logic [TAG_W-1:0]              i_tag,
    output t_stat                         o_stat,
    output logic [STAT_W-1:0]             o_status,
    output logic [TAG_W-1:0]              o_found_tag
);

    localparam int CELLS = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int CAW   = $clog2(CELLS);
    localparam int GW    = $clog2(MAX_GRID + 1);
    localparam int IW    = $clog2(MAX_GRID);
    localparam int DW    = IW + 1;
    localparam int PW    = $clog2(MAX_POINTS + 1);
    localparam int CB    = COORD_BITS;
    localparam int SW    = 2 * CB + 2;
    localparam int PRW   = GW + CB;

    logic [PW-1:0]   m_head [0:CELLS-1];
    logic [PW-1:0]   m_next [0:MAX_POINTS];
    logic [3*CB-1:0] m_pos  [0:MAX_POINTS];
    logic [TAG_W-1:0] m_val [0:MAX_POINTS];

    logic [CB-1:0]    r_cx, r_cy, r_cz;
    logic [TAG_W-1:0] r_tag;
    logic [PRW-1:0]   r_px, r_py, r_pz;
    logic [IW-1:0]    r_ci, r_cj, r_ck;
    logic [IW-1:0]    r_i, r_j, r_k;
    logic [IW-1:0]    r_i0, r_j0, r_k0, r_i1, r_j1, r_k1;
    logic [DW-1:0]    r_d;
    logic [CAW-1:0]   r_kj, r_addr, r_cnt;
    logic [PW-1:0]    r_head_q, r_points, r_p, r_nxt_q;
    logic [3*CB-1:0]  r_pos_q;
    logic [TAG_W-1:0] r_val_q, r_best, r_found;
    logic [2*CB-1:0]  r_sqx, r_sqy, r_sqz;
    logic [SW-1:0]    r_bd;
    logic             r_first;
    t_status          r_status;

    logic [PW-1:0]    n_pt;
    logic [SW-1:0]    n_sum;
    logic [IW-1:0]    lo_i, lo_j, lo_k;

    function automatic logic [IW-1:0] axis_idx(input logic [PRW-1:0] p,
                                               input logic [GW-1:0] g);
        logic [GW-1:0] q;
        logic [GW-1:0] v;
        q = p[PRW-1:CB];
        v = (q == '0) ? '0 : q - GW'(1);
        if (v > g - GW'(1)) v = g - GW'(1);
        return IW'(v);
    endfunction

    function automatic logic [IW-1:0] box_lo(input logic [IW-1:0] c, input logic [DW-1:0] d);
        return ({1'b0, c} >= d) ? IW'({1'b0, c} - d) : '0;
    endfunction

    function automatic logic [IW-1:0] box_hi(input logic [IW-1:0] c, input logic [DW-1:0] d,
                                             input logic [GW-1:0] g);
        logic [DW+GW:0] s;
        logic [DW+GW:0] t;
        s = (DW+GW+1)'(c) + (DW+GW+1)'(d);
        t = (DW+GW+1)'(g) - (DW+GW+1)'(1);
        return (s > t) ? IW'(t) : IW'(s);
    endfunction

    function automatic logic [2*CB-1:0] sq_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB-1:0] d;
        d = (a > b) ? a - b : b - a;
        return (2*CB)'(d) * (2*CB)'(d);
    endfunction

    assign n_pt  = r_points + PW'(1);
    assign n_sum = SW'(r_sqx) + SW'(r_sqy) + SW'(r_sqz);
    assign lo_i  = box_lo(r_ci, r_d);
    assign lo_j  = box_lo(r_cj, r_d);
    assign lo_k  = box_lo(r_ck, r_d);

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_points <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_cnt <= o_stat.clr_last ? '0 : r_cnt + CAW'(1);
                if (o_stat.clr_last) r_points <= '0;
            end else if (i_cmd.ins) begin
                r_points <= n_pt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            m_head[r_cnt] <= '0;
        end else if (i_cmd.ins) begin
            m_head[r_addr] <= n_pt;
        end
        if (i_cmd.rd_head) r_head_q <= m_head[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            m_next[n_pt] <= r_head_q;
            m_pos[n_pt]  <= {r_cz, r_cy, r_cx};
            m_val[n_pt]  <= r_tag;
        end
        if (i_cmd.rd_pt) begin
            r_nxt_q <= m_next[r_p];
            r_pos_q <= m_pos[r_p];
            r_val_q <= m_val[r_p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx  <= CB'(i_coord_x);
            r_cy  <= CB'(i_coord_y);
            r_cz  <= CB'(i_coord_z);
            r_tag <= i_tag;
        end
        if (i_cmd.idx_mul) begin
            r_px <= PRW'(i_g) * PRW'(r_cx);
            r_py <= PRW'(i_g) * PRW'(r_cy);
            r_pz <= PRW'(i_g) * PRW'(r_cz);
        end
        if (i_cmd.idx_clamp) begin
            r_ci <= axis_idx(r_px, i_g);
            r_cj <= axis_idx(r_py, i_g);
            r_ck <= axis_idx(r_pz, i_g);
            r_i  <= axis_idx(r_px, i_g);
            r_j  <= axis_idx(r_py, i_g);
            r_k  <= axis_idx(r_pz, i_g);
        end
        if (i_cmd.adr_kj) r_kj <= CAW'(r_k) * CAW'(i_g) + CAW'(r_j);
        if (i_cmd.adr_fin) r_addr <= r_kj * CAW'(i_g) + CAW'(r_i);
        if (i_cmd.ring_d1) r_d <= DW'(1);
        if (i_cmd.ring_bounds) begin
            r_i0 <= lo_i;
            r_j0 <= lo_j;
            r_k0 <= lo_k;
            r_i1 <= box_hi(r_ci, r_d, i_g);
            r_j1 <= box_hi(r_cj, r_d, i_g);
            r_k1 <= box_hi(r_ck, r_d, i_g);
            r_i  <= lo_i;
            r_j  <= lo_j;
            r_k  <= lo_k;
        end
        if (i_cmd.ring_step) begin
            if (r_i != r_i1) begin
                r_i <= r_i + IW'(1);
            end else begin
                r_i <= r_i0;
                if (r_j != r_j1) begin
                    r_j <= r_j + IW'(1);
                end else begin
                    r_j <= r_j0;
                    if (r_k != r_k1) r_k <= r_k + IW'(1);
                    else r_d <= r_d + DW'(1);
                end
            end
        end
        if (i_cmd.pt_first) begin
            r_p     <= r_head_q;
            r_first <= 1'b1;
        end
        if (i_cmd.dist_sq) begin
            r_sqx <= sq_diff(r_pos_q[CB-1:0], r_cx);
            r_sqy <= sq_diff(r_pos_q[2*CB-1:CB], r_cy);
            r_sqz <= sq_diff(r_pos_q[3*CB-1:2*CB], r_cz);
        end
        if (i_cmd.dist_acc) begin
            r_p     <= r_nxt_q;
            r_first <= 1'b0;
            // strict compare: first point met wins a tie
            if (r_first || (n_sum < r_bd)) begin
                r_bd   <= n_sum;
                r_best <= r_val_q;
            end
        end
        if (i_cmd.res_we) begin
            r_status <= i_cmd.res_code;
            case (i_cmd.res_code)
                ST_OWN:  r_found <= r_best;
                ST_NBR:  r_found <= r_val_q;
                default: r_found <= '0;
            endcase
        end
    end

    always_comb begin
        o_stat.full      = (r_points == PW'(MAX_POINTS));
        o_stat.clr_last  = (r_cnt == CAW'(CELLS - 1));
        o_stat.head_nz   = (r_head_q != '0);
        o_stat.nxt_nz    = (r_nxt_q != '0);
        o_stat.centre    = (r_i == r_ci) && (r_j == r_cj) && (r_k == r_ck);
        o_stat.box_end   = (r_i == r_i1) && (r_j == r_j1) && (r_k == r_k1);
        o_stat.ring_more = ((GW+2)'(r_d) + (GW+2)'(1)) < (GW+2)'(i_g >> 1);
    end

    assign o_status    = r_status;
    assign o_found_tag = r_found;

endmodule

// ----- design/grid_bucket_nearest_point_3d_unit.sv -----
// Top level of the 3D grid-bucket nearest-point unit: config register, sequencer, datapath.
// Depends on gbnp3d_pkg, gbnp3d_ctrl, gbnp3d_dp.
//
// Usage:
//   Command beat: start with i_opcode, coordinates and i_point_tag, taken when
//   busy is low. Opcodes: clear, insert, query, nop. One result beat per command,
//   o_valid high for one cycle with o_status and o_found_tag; it cannot be held.
//   Config: i_cfg_valid / o_cfg_ready write i_cfg_grid_size; write only when idle
//   and clear the grid afterwards. o_cfg_ready is always high.
// Sequence from accept to o_valid:
//   clear:  sweeps all MAX_GRID^3 cell heads, one cell head zeroed per cycle
//   insert: index, clamp, address, head read, link; or ST_FULL when the store is full
//   query in own cell: head read, then one point-store read per chain point
//   query by ring scan: one head read per cell scanned, ring by ring outward
//   One command at a time: busy stays high until the result beat.
// Reset: grid_size returns to 16, then a clearing pass over all MAX_GRID^3 cell heads
//   runs with busy high; commands are taken after it, config writes at any time.
// The receiver cannot stall: each result is shown for exactly one cycle.
module grid_bucket_nearest_point_3d_unit import gbnp3d_pkg::*; #(
    parameter int MAX_GRID   = MAX_GRID_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [IN_COORD_W-1:0] i_coord_x,
    input  logic [IN_COORD_W-1:0] i_coord_y,
    input  logic [IN_COORD_W-1:0] i_coord_z,
    input  logic [TAG_W-1:0]      i_point_tag,
    output logic                  o_valid,
    output logic [STAT_W-1:0]     o_status,
    output logic [TAG_W-1:0]      o_found_tag,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_grid_size
);

    localparam int GW = $clog2(MAX_GRID + 1);

    logic [CFG_W-1:0] r_grid_size;
    logic [GW-1:0]    g_eff;
    t_cmd             cmd;
    t_stat            stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= CFG_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_grid_size <= i_cfg_grid_size;
        end
    end

    always_comb begin
        if (r_grid_size == '0) g_eff = GW'(1);
        else if (32'(r_grid_size) > MAX_GRID) g_eff = GW'(MAX_GRID);
        else g_eff = GW'(r_grid_size);
    end

    gbnp3d_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    gbnp3d_dp #(
        .MAX_GRID   (MAX_GRID),
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_g         (g_eff),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_coord_z   (i_coord_z),
        .i_tag       (i_point_tag),
        .o_stat      (stat),
        .o_status    (o_status),
        .o_found_tag (o_found_tag)
    );

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command beat not followed by busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat longer than one cycle");

    a_valid_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat outside a busy command");

    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OWN && o_status != ST_NBR) |-> (o_found_tag == '0))
        else $error("non-zero tag on a result without a point");

    a_no_full_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_CLEARED) |-> !stat.full)
        else $error("store count not reset by clear");

endmodule

// ----- verif/gbnp3d_checker.sv -----
`timescale 1ns / 1ps
// Checker for the 3D grid-bucket nearest-point unit: predicts each result beat
// from the accepted command beats and config writes, and compares. Depends on gbnp3d_pkg.
module gbnp3d_checker import gbnp3d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [IN_COORD_W-1:0] i_coord_x,
    input  logic [IN_COORD_W-1:0] i_coord_y,
    input  logic [IN_COORD_W-1:0] i_coord_z,
    input  logic [TAG_W-1:0]      i_point_tag,
    input  logic                  o_valid,
    input  logic [STAT_W-1:0]     o_status,
    input  logic [TAG_W-1:0]      o_found_tag,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_grid_size,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_beats_seen,
    output int                    o_nbr_hits
);

    localparam int NCELLS = MAX_GRID_DEF * MAX_GRID_DEF * MAX_GRID_DEF;

    typedef struct packed {
        t_status         status;
        logic [TAG_W-1:0] tag;
    } t_answer;

    logic [CFG_W-1:0] grid_reg;
    logic [12:0]      head_of[NCELLS];
    logic [12:0]      chain_next[MAX_POINTS_DEF+1];
    logic [15:0]      pos_x[MAX_POINTS_DEF+1];
    logic [15:0]      pos_y[MAX_POINTS_DEF+1];
    logic [15:0]      pos_z[MAX_POINTS_DEF+1];
    logic [15:0]      tag_of[MAX_POINTS_DEF+1];
    int               n_points;
    t_answer          answers_due[$];

    function automatic int axis_cell(int g, logic [15:0] c);
        int v;
        v = ((g * int'(c)) >>> 16) - 1;
        if (v < 0) v = 0;
        if (v > g - 1) v = g - 1;
        return v;
    endfunction

    function automatic longint dist2(int p, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        longint dx, dy, dz;
        dx = longint'(pos_x[p]) - longint'(x);
        dy = longint'(pos_y[p]) - longint'(y);
        dz = longint'(pos_z[p]) - longint'(z);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    function automatic t_answer apply_command(t_op op, logic [15:0] x, logic [15:0] y,
                                              logic [15:0] z, logic [15:0] tg);
        t_answer a;
        int g, ci, cj, ck, cell_ix, p, best, guard, d, top;
        int i0, i1, j0, j1, k0, k1;
        longint bd, d2;
        bit hit;
        g = (grid_reg == 0) ? 1 : (grid_reg > MAX_GRID_DEF) ? MAX_GRID_DEF : int'(grid_reg);
        ci = axis_cell(g, x);
        cj = axis_cell(g, y);
        ck = axis_cell(g, z);
        cell_ix = ((ck * g + cj) * g + ci) % NCELLS;
        a.status = ST_NONE;
        a.tag = '0;
        case (op)
            OP_CLEAR: begin
                foreach (head_of[n]) head_of[n] = '0;
                n_points = 0;
                a.status = ST_CLEARED;
            end
            OP_INSERT: begin
                if (n_points >= MAX_POINTS_DEF) begin
                    a.status = ST_FULL;
                end else begin
                    n_points++;
                    pos_x[n_points] = x;
                    pos_y[n_points] = y;
                    pos_z[n_points] = z;
                    tag_of[n_points] = tg;
                    chain_next[n_points] = head_of[cell_ix];
                    head_of[cell_ix] = 13'(n_points);
                    a.status = ST_INSERTED;
                end
            end
            OP_QUERY: begin
                p = head_of[cell_ix];
                if (p != 0) begin
                    best = p;
                    bd = dist2(p, x, y, z);
                    p = chain_next[p];
                    guard = 0;
                    while (p != 0 && guard < MAX_POINTS_DEF) begin
                        d2 = dist2(p, x, y, z);
                        if (d2 < bd) begin
                            bd = d2;
                            best = p;
                        end
                        p = chain_next[p];
                        guard++;
                    end
                    a.status = ST_OWN;
                    a.tag = tag_of[best];
                end else begin
                    d = 1;
                    top = g - 1;
                    hit = 0;
                    do begin
                        i0 = (ci - d < 0) ? 0 : ci - d;
                        i1 = (ci + d > top) ? top : ci + d;
                        j0 = (cj - d < 0) ? 0 : cj - d;
                        j1 = (cj + d > top) ? top : cj + d;
                        k0 = (ck - d < 0) ? 0 : ck - d;
                        k1 = (ck + d > top) ? top : ck + d;
                        for (int k = k0; k <= k1 && !hit; k++)
                            for (int j = j0; j <= j1 && !hit; j++)
                                for (int i = i0; i <= i1 && !hit; i++) begin
                                    if (!(i == ci && j == cj && k == ck)) begin
                                        p = head_of[((k * g + j) * g + i) % NCELLS];
                                        if (p != 0) begin
                                            hit = 1;
                                            a.status = ST_NBR;
                                            a.tag = tag_of[p];
                                        end
                                    end
                                end
                        d++;
                    end while (!hit && d < g / 2);
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    initial begin
        grid_reg = 5'd16;
        foreach (head_of[n]) head_of[n] = '0;
        n_points = 0;
        o_fail_count = 0;
        o_beats_seen = 0;
        o_nbr_hits = 0;
    end

    assign o_pending = answers_due.size();

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            grid_reg <= 5'd16;
        end else begin
            if (i_cfg_valid && o_cfg_ready) grid_reg <= i_cfg_grid_size;
            if (start && !busy)
                answers_due.push_back(apply_command(t_op'(i_opcode), i_coord_x, i_coord_y,
                                                    i_coord_z, i_point_tag));
            if (o_valid) begin
                o_beats_seen <= o_beats_seen + 1;
                if (answers_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("[%0t] unexpected result beat: status %0d tag %0h",
                                 $realtime, o_status, o_found_tag);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (o_status == ST_NBR) o_nbr_hits <= o_nbr_hits + 1;
                    if (o_status !== want.status || o_found_tag !== want.tag) begin
                        if (o_fail_count < 10)
                            $display("[%0t] mismatch: expected status %0d tag %0h, got %0d %0h",
                                     $realtime, want.status, want.tag, o_status, o_found_tag);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- verif/tb_grid_bucket_nearest_point_3d_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for grid_bucket_nearest_point_3d_unit: clock, reset, command and
// config stimulus, verdict. Depends on gbnp3d_pkg, gbnp3d_checker and the unit itself.
module tb_grid_bucket_nearest_point_3d_unit;
    import gbnp3d_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_opcode = OP_NOP;
    logic [IN_COORD_W-1:0] i_coord_x = '0;
    logic [IN_COORD_W-1:0] i_coord_y = '0;
    logic [IN_COORD_W-1:0] i_coord_z = '0;
    logic [TAG_W-1:0]      i_point_tag = '0;
    logic                  o_valid;
    logic [STAT_W-1:0]     o_status;
    logic [TAG_W-1:0]      o_found_tag;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_grid_size = '0;
    int                    fail_count, pending, beats_seen, nbr_hits;
    bit                    gaps_on;
    logic [15:0]           recent_x[8], recent_y[8], recent_z[8];
    int                    cmds_sent;

    always #6 i_clk = ~i_clk;

    grid_bucket_nearest_point_3d_unit dut (.*);

    gbnp3d_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_opcode, .i_coord_x, .i_coord_y, .i_coord_z,
        .i_point_tag, .o_valid, .o_status, .o_found_tag, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_grid_size,
        .o_fail_count(fail_count), .o_pending(pending), .o_beats_seen(beats_seen),
        .o_nbr_hits(nbr_hits)
    );

    task automatic send_cmd(t_op op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            logic [15:0] tg);
        start <= 1'b1;
        i_opcode <= op;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        i_point_tag <= tg;
        do @(posedge i_clk); while (busy);
        cmds_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic set_grid(logic [CFG_W-1:0] g);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_grid_size <= g;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        send_cmd(OP_CLEAR, '0, '0, '0, '0);
    endtask

    task automatic random_cmd();
        logic [15:0] x, y, z;
        int r, m, s;
        r = $urandom_range(0, 99);
        m = $urandom_range(0, 7);
        s = $urandom_range(0, 7);
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
        if (m == 0) begin
            x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            z = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else if (m < 3) begin
            x = recent_x[s] + 16'($urandom_range(0, 6)) - 16'd3;
            y = recent_y[s] + 16'($urandom_range(0, 6)) - 16'd3;
            z = recent_z[s] + 16'($urandom_range(0, 6)) - 16'd3;
        end else if (m == 3) begin
            x = recent_x[s];
            y = recent_y[s];
            z = recent_z[s];
        end
        if (r < 2) begin
            send_cmd(OP_CLEAR, x, y, z, 16'($urandom));
        end else if (r < 5) begin
            send_cmd(OP_NOP, x, y, z, 16'($urandom));
        end else if (r < 52) begin
            recent_x[s] = x;
            recent_y[s] = y;
            recent_z[s] = z;
            send_cmd(OP_INSERT, x, y, z, 16'($urandom));
        end else begin
            send_cmd(OP_QUERY, x, y, z, 16'($urandom));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] grids[10];
        grids = '{5'd1, 5'd2, 5'd0, 5'd31, 5'd3, 5'd16, 5'd5, 5'd8, 5'd4, 5'd16};
        cmds_sent = 0;
        gaps_on = 1'b1;
        foreach (recent_x[n]) begin
            recent_x[n] = 16'($urandom);
            recent_y[n] = 16'($urandom);
            recent_z[n] = 16'($urandom);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty grid, extremes, tie, nop, neighbour search
        send_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h1234);
        send_cmd(OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_cmd(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_cmd(OP_INSERT, 16'h8000, 16'h8000, 16'h8000, 16'hAAAA);
        send_cmd(OP_INSERT, 16'h8000, 16'h8000, 16'h8000, 16'h5555);
        send_cmd(OP_QUERY, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
        send_cmd(OP_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(OP_QUERY, 16'h1000, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(OP_QUERY, 16'h3000, 16'h9000, 16'h2000, 16'h0000);
        send_cmd(OP_NOP, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_cmd(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(OP_QUERY, 16'h8000, 16'h8000, 16'h8000, 16'h0000);

        repeat (30) random_cmd();
        send_cmd(OP_CLEAR, '0, '0, '0, '0);

        foreach (grids[p]) begin
            set_grid(grids[p]);
            if (p == 9) gaps_on = 1'b0;
            else gaps_on = $urandom_range(0, 3) != 0;
            repeat (160) random_cmd();
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d commands over ten grid sizes, clears and nops mixed in;", cmds_sent);
        $display("%0d result beats checked, %0d neighbour-cell hits.", beats_seen, nbr_hits);
        if (fail_count == 0)
            $display("** grid_bucket_nearest_point_3d_unit: PASSED **");
        else
            $display("** grid_bucket_nearest_point_3d_unit: FAILED **");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("** grid_bucket_nearest_point_3d_unit: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/gbnp3d_pkg.sv
design/gbnp3d_ctrl.sv
design/gbnp3d_dp.sv
design/grid_bucket_nearest_point_3d_unit.sv
verif/gbnp3d_checker.sv
verif/tb_grid_bucket_nearest_point_3d_unit.sv
